// ===== rtl/core/savc_pkg.sv =====
// Shared types and constants for the set-associative cache with victim buffer.
// Used by the controller, the datapath and the top level.
package savc_pkg;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Result codes
  localparam logic [1:0] OUT_MISS    = 2'd0;
  localparam logic [1:0] OUT_HIT     = 2'd1;
  localparam logic [1:0] OUT_VICTIM  = 2'd2;

  // Register indexes on the configuration port
  localparam logic [0:0] REG_VICTIM_ENABLE = 1'd0;
  localparam logic [0:0] REG_OFFSET_BITS   = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOOKUP,
    ST_SCAN,
    ST_WRITE,
    ST_CLEAR,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture a new request
    logic rd_set;    // read the set's ways into the working registers
    logic lookup;    // compare tags and the victim buffer
    logic scan;      // step the minimum-count search
    logic commit;    // write the set and victim buffer back
    logic clr;       // clear one set of the tag store after reset
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic clr_done;
  } dp_sts_t;

endpackage

// ===== rtl/core/savc_ctrl.sv =====
// Controller state machine for the cache: sequences read, lookup, search and write-back.
// Depends on savc_pkg.
module savc_ctrl
  import savc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_set = 1'b1;
        state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.commit = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  // A result is only offered after a write-back
  a_out_after_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit)) else $error("result without write-back");
  // A new request is never taken while a result waits
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request taken while busy");
  // Only one command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd)) else $error("overlapping commands");
`endif

endmodule

// ===== rtl/core/savc_dp.sv =====
// Datapath: tag store memory, use counts, victim buffer, minimum search and miss count.
// Depends on savc_pkg.
module savc_dp
  import savc_pkg::*;
#(
  parameter int SETS = 64,
  parameter int WAYS = 4,
  parameter int VICTIM_ENTRIES = 4,
  parameter int ADDR_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [31:0] address,
  input  logic        victim_enable,
  input  logic [3:0]  offset_bits,
  output logic [1:0]  outcome,
  output logic [1:0]  way_used,
  output logic [31:0] miss_count
);

  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int VW = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;
  localparam int SCW = $clog2(WAYS + VICTIM_ENTRIES + 1);
  localparam logic [31:0] SETS_C = 32'(SETS);
  localparam logic [63:0] AMASK = (ADDR_WIDTH >= 32) ? 64'hFFFF_FFFF
                                  : ((64'd1 << ADDR_WIDTH) - 64'd1);

  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [31:0] uses;
  } line_t;

  // One memory row holds a whole set
  line_t mem [SETS][WAYS];
  line_t rd_row [WAYS];
  line_t row [WAYS];
  line_t row_n [WAYS];

  logic [31:0] v_addr [VICTIM_ENTRIES];
  logic        v_valid [VICTIM_ENTRIES];
  logic [31:0] v_uses [VICTIM_ENTRIES];

  logic [31:0] line, tag, misses;
  logic [SW-1:0] set;
  logic [SW-1:0] set_c;
  logic [SW:0]   clr_idx;
  logic [1:0]  res_kind;
  logic        hit_main, hit_vic, has_free;
  logic [WW-1:0] hit_way, free_w, sel_way;
  logic [VW-1:0] hit_ent;
  logic        v_has_free;
  logic [VW-1:0] v_free;

  // Minimum search, one element a cycle: ways first, then victim entries
  logic [SCW-1:0] scan_i;
  logic [31:0]    min_w_cnt, min_v_cnt;
  logic [WW-1:0]  min_w;
  logic [VW-1:0]  min_v;

  // Line address, set and tag (division by a constant)
  logic [31:0] line_c;
  assign line_c = 32'((64'(address) & AMASK) >> offset_bits);
  assign set_c  = SW'(line_c % SETS_C);

  // Clearing pass and memory write/read; the read follows the new set as it is loaded
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      for (int w = 0; w < WAYS; w++) mem[clr_idx[SW-1:0]][w] <= '0;
    end else if (cmd.commit) begin
      for (int w = 0; w < WAYS; w++) mem[set][w] <= row_n[w];
    end
    for (int w = 0; w < WAYS; w++) rd_row[w] <= mem[cmd.load ? set_c : set][w];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_idx <= '0;
    else if (cmd.clr && clr_idx != (SW+1)'(SETS)) clr_idx <= clr_idx + 1'b1;
  end

  // Status to the controller
  assign sts = '{scan_done: (scan_i == SCW'(WAYS + VICTIM_ENTRIES - 1)),
                 clr_done:  ((clr_idx == (SW+1)'(SETS - 1)) || (clr_idx == (SW+1)'(SETS)))};

  // Lookup on the registered set
  always_comb begin
    hit_main = 1'b0; hit_way = '0; has_free = 1'b0; free_w = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row[w].valid && row[w].tag == tag) begin
        hit_main = 1'b1; hit_way = WW'(w);
      end
      if (!row[w].valid) begin
        has_free = 1'b1; free_w = WW'(w);
      end
    end
    hit_vic = 1'b0; hit_ent = '0; v_has_free = 1'b0; v_free = '0;
    for (int e = VICTIM_ENTRIES - 1; e >= 0; e--) begin
      if (v_valid[e] && v_addr[e] == line) begin
        hit_vic = victim_enable; hit_ent = VW'(e);
      end
      if (!v_valid[e]) begin
        v_has_free = 1'b1; v_free = VW'(e);
      end
    end
  end

  // Working registers, search and write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      misses <= '0;
      for (int e = 0; e < VICTIM_ENTRIES; e++) begin
        v_valid[e] <= 1'b0; v_addr[e] <= '0; v_uses[e] <= '0;
      end
    end else begin
      if (cmd.load) begin
        line <= line_c;
        set  <= set_c;
        tag  <= line_c / SETS_C;
      end
      if (cmd.rd_set) begin
        for (int w = 0; w < WAYS; w++) row[w] <= rd_row[w];
      end
      if (cmd.lookup) begin
        scan_i    <= '0;
        min_w     <= '0;
        min_w_cnt <= row[0].uses;
        min_v     <= '0;
        min_v_cnt <= v_uses[0];
        if (hit_main) begin
          res_kind <= OUT_HIT; sel_way <= hit_way;
        end else if (hit_vic) begin
          res_kind <= OUT_VICTIM;
        end else begin
          res_kind <= OUT_MISS;
          if (misses != COUNT_MAX) misses <= misses + 1'b1;
        end
      end
      if (cmd.scan) begin
        scan_i <= scan_i + 1'b1;
        if (scan_i < SCW'(WAYS)) begin
          if (row[WW'(scan_i)].uses < min_w_cnt) begin
            min_w_cnt <= row[WW'(scan_i)].uses; min_w <= WW'(scan_i);
          end
        end else if (v_uses[VW'(scan_i - SCW'(WAYS))] < min_v_cnt) begin
          min_v_cnt <= v_uses[VW'(scan_i - SCW'(WAYS))];
          min_v     <= VW'(scan_i - SCW'(WAYS));
        end
      end
      if (cmd.commit) begin
        for (int w = 0; w < WAYS; w++) row[w] <= row_n[w];
        if (res_kind == OUT_VICTIM) begin
          if (has_free) begin
            sel_way <= free_w;
            v_valid[hit_ent] <= 1'b0; v_addr[hit_ent] <= '0; v_uses[hit_ent] <= '0;
          end else begin
            sel_way <= min_w;
            v_valid[hit_ent] <= 1'b1;
            v_addr[hit_ent]  <= 32'(row[min_w].tag * SETS_C) + 32'(set);
            v_uses[hit_ent]  <= row[min_w].uses;
          end
        end else if (res_kind == OUT_MISS) begin
          sel_way <= has_free ? free_w : min_w;
          if (!has_free && victim_enable) begin
            v_valid[v_has_free ? v_free : min_v] <= 1'b1;
            v_addr[v_has_free ? v_free : min_v]  <=
              32'(row[min_w].tag * SETS_C) + 32'(set);
            v_uses[v_has_free ? v_free : min_v]  <= row[min_w].uses;
          end
        end
      end
    end
  end

  // New contents of the set for the write-back
  always_comb begin
    logic [WW-1:0] tw;
    logic [31:0]   vc;
    tw = has_free ? free_w : min_w;
    vc = (v_uses[hit_ent] == COUNT_MAX) ? COUNT_MAX : v_uses[hit_ent] + 1'b1;
    for (int w = 0; w < WAYS; w++) row_n[w] = row[w];
    if (res_kind == OUT_HIT) begin
      if (row[hit_way].uses != COUNT_MAX) row_n[hit_way].uses = row[hit_way].uses + 1'b1;
    end else if (res_kind == OUT_VICTIM) begin
      row_n[tw] = '{valid: 1'b1, tag: tag, uses: vc};
    end else begin
      row_n[tw] = '{valid: 1'b1, tag: tag, uses: 32'd1};
    end
  end

  assign outcome    = res_kind;
  assign way_used   = 2'(sel_way);
  assign miss_count = misses;

endmodule

// ===== rtl/core/set_assoc_cache_with_victim_buffer_unit.sv =====
// Top level of the set-associative cache with victim buffer: APB registers, controller, datapath.
// Depends on savc_pkg, savc_ctrl and savc_dp.
//
// One address is taken at a time; each request passes from acceptance to result through
// a set read, a lookup, a one-element-a-cycle minimum-count search over the ways and victim
// entries, and a write-back. The next request is taken only once the result has been accepted
// and the controller is back in idle. After reset a clearing pass empties the tag store, one
// set at a time, before the first request is taken.
module set_assoc_cache_with_victim_buffer_unit
  import savc_pkg::*;
#(
  parameter int SETS = 64,
  parameter int WAYS = 4,
  parameter int VICTIM_ENTRIES = 4,
  parameter int ADDR_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  outcome,
  output logic [1:0]  way_used,
  output logic [31:0] miss_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       victim_enable;
  logic [3:0] offset_bits;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  assign pready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      victim_enable <= 1'b1;
      offset_bits   <= 4'd5;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && !paddr[2]) begin
      victim_enable <= pwdata[0];
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == REG_OFFSET_BITS) begin
      offset_bits <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_VICTIM_ENABLE) prdata[0] = victim_enable;
    else prdata[3:0] = offset_bits;
  end

  savc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  savc_dp #(
    .SETS(SETS), .WAYS(WAYS), .VICTIM_ENTRIES(VICTIM_ENTRIES), .ADDR_WIDTH(ADDR_WIDTH)
  ) u_dp (
    .clk, .rst, .cmd, .sts, .address, .victim_enable, .offset_bits,
    .outcome, .way_used, .miss_count
  );

`ifndef ASSERT_OFF
  // Result codes stay in range while offered
  a_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (outcome == OUT_MISS || outcome == OUT_HIT || outcome == OUT_VICTIM))
    else $error("bad outcome");
  // The miss count only ever moves up by one
  a_miss_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && miss_count != $past(miss_count) |-> miss_count == $past(miss_count) + 32'd1)
    else $error("miss step");
  // A stalled result holds its values
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(miss_count) && $stable(way_used))
    else $error("stalled result changed");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the set-associative cache with victim buffer.
// Depends on savc_pkg and set_assoc_cache_with_victim_buffer_unit; drives and checks via ports.
module testbench;
  import savc_pkg::*;

  localparam int NSETS = 64;
  localparam int NWAYS = 4;
  localparam int NVICT = 4;
  localparam int LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [1:0]  way_used;
    logic [31:0] miss_count;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  outcome;
  logic [1:0]  way_used;
  logic [31:0] miss_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  set_assoc_cache_with_victim_buffer_unit DUT (.*);

  always #5 clk = ~clk;

  // Shadow cache state
  logic [25:0] sh_tag [NSETS*NWAYS];
  logic        sh_valid [NSETS*NWAYS];
  logic [31:0] sh_uses [NSETS*NWAYS];
  logic [31:0] vb_line [NVICT];
  logic        vb_valid [NVICT];
  logic [31:0] vb_uses [NVICT];
  logic [31:0] sh_misses;
  logic        cfg_victim;
  logic [3:0]  cfg_offset;

  logic [31:0] pending_addr [$];
  result_t     expected_results [$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          send_wait = 0;
  int          recv_wait = 0;

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

  function automatic int least_way(int base);
    int best;
    best = 0;
    for (int w = 1; w < NWAYS; w++)
      if (sh_uses[base+w] < sh_uses[base+best]) best = w;
    return best;
  endfunction

  function automatic int free_way(int base);
    for (int w = 0; w < NWAYS; w++)
      if (!sh_valid[base+w]) return w;
    return -1;
  endfunction

  // Predict the result of one access and update the shadow state
  function automatic result_t access_cache(logic [31:0] addr);
    result_t r;
    logic [31:0] line;
    logic [25:0] tag;
    int set, base, way, f, slot;
    logic [31:0] cnt;
    line = addr >> cfg_offset;
    set = int'(line % NSETS);
    tag = 26'(line / NSETS);
    base = set * NWAYS;
    for (int w = 0; w < NWAYS; w++) begin
      if (sh_valid[base+w] && sh_tag[base+w] == tag) begin
        sh_uses[base+w] = bump(sh_uses[base+w]);
        r.outcome = OUT_HIT; r.way_used = 2'(w); r.miss_count = sh_misses;
        return r;
      end
    end
    if (cfg_victim) begin
      for (int e = 0; e < NVICT; e++) begin
        if (vb_valid[e] && vb_line[e] == line) begin
          cnt = bump(vb_uses[e]);
          f = free_way(base);
          if (f >= 0) begin
            way = f;
            vb_valid[e] = 1'b0; vb_line[e] = '0; vb_uses[e] = '0;
          end else begin
            way = least_way(base);
            vb_line[e] = {6'd0, sh_tag[base+way]} * NSETS + set;
            vb_uses[e] = sh_uses[base+way];
            vb_valid[e] = 1'b1;
          end
          sh_tag[base+way] = tag; sh_uses[base+way] = cnt; sh_valid[base+way] = 1'b1;
          r.outcome = OUT_VICTIM; r.way_used = 2'(way); r.miss_count = sh_misses;
          return r;
        end
      end
    end
    sh_misses = bump(sh_misses);
    f = free_way(base);
    if (f >= 0) begin
      way = f;
    end else begin
      way = least_way(base);
      if (cfg_victim) begin
        slot = -1;
        for (int e = 0; e < NVICT; e++)
          if (!vb_valid[e] && slot < 0) slot = e;
        if (slot < 0) begin
          slot = 0;
          for (int e = 1; e < NVICT; e++)
            if (vb_uses[e] < vb_uses[slot]) slot = e;
        end
        vb_line[slot] = {6'd0, sh_tag[base+way]} * NSETS + set;
        vb_uses[slot] = sh_uses[base+way];
        vb_valid[slot] = 1'b1;
      end
    end
    sh_tag[base+way] = tag; sh_uses[base+way] = 32'd1; sh_valid[base+way] = 1'b1;
    r.outcome = OUT_MISS; r.way_used = 2'(way); r.miss_count = sh_misses;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Append one address to the pending requests
  task automatic queue_addr(logic [31:0] a);
    pending_addr.insert(pending_addr.size(), a);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(), access_cache(address));
        send_wait <= $urandom_range(0, 13);
        if (pending_addr.size() > 0 && $urandom_range(0, 13) == 0) begin
          address <= pending_addr.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (send_wait > 0) send_wait <= send_wait - 1;
        else if (pending_addr.size() > 0) begin
          in_valid <= 1'b1;
          address <= pending_addr.pop_front();
        end
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", {30'd0, outcome}, '0);
        end else begin
          want = expected_results.pop_front();
          if (outcome !== want.outcome) report("outcome", {30'd0, outcome}, {30'd0, want.outcome});
          if (way_used !== want.way_used) report("way_used", {30'd0, way_used}, {30'd0, want.way_used});
          if (miss_count !== want.miss_count) report("miss_count", miss_count, want.miss_count);
        end
        recv_wait = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) recv_wait = 0;
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_stall <= (recv_wait > 0);
    end
  end

  // Watchdog on accepted traffic
  always @(posedge clk) begin
    if (rst || psel || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (pending_addr.size() == 0 && expected_results.size() == 0 && !in_valid))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd4 * REG_VICTIM_ENABLE) cfg_victim = data[0];
    else cfg_offset = data[3:0];
  endtask

  task automatic drain();
    wait (pending_addr.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  // Well-formed traffic: mostly revisits a small pool of conflicting lines, with some random addresses
  task automatic queue_random(int n);
    logic [31:0] pool [8];
    int k;
    for (int i = 0; i < 8; i++)
      pool[i] = {4'($urandom_range(0, 15)), 4'd0, 6'($urandom_range(0, 2)), 2'd0,
                 16'($urandom)} << ($urandom_range(0, 1) * 5);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k < 8) queue_addr(pool[k] ^ 32'($urandom_range(0, 31)));
      else queue_addr($urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < NSETS*NWAYS; i++) begin
      sh_tag[i] = '0; sh_valid[i] = 1'b0; sh_uses[i] = '0;
    end
    for (int e = 0; e < NVICT; e++) begin
      vb_line[e] = '0; vb_valid[e] = 1'b0; vb_uses[e] = '0;
    end
    sh_misses = '0; cfg_victim = 1'b1; cfg_offset = 4'd5;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, same-set thrash to force evictions and victim hits
    queue_addr(32'h0000_0000);
    queue_addr(32'hFFFF_FFFF);
    queue_addr(32'h0000_001F);
    queue_addr(32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) queue_addr(32'(i) << 11);
    for (int i = 0; i < 6; i++) queue_addr(32'(i) << 11);
    queue_addr(32'hAAAA_5555);
    queue_addr(32'h5555_AAAA);
    drain();

    // Victim buffer off; buffer keeps its contents
    reg_write(3'd4 * REG_VICTIM_ENABLE, 32'd0);
    reg_write(3'd4 * REG_OFFSET_BITS, 32'd0);
    queue_random(120);
    drain();

    reg_write(3'd4 * REG_VICTIM_ENABLE, 32'd1);
    reg_write(3'd4 * REG_OFFSET_BITS, 32'd12);
    queue_random(120);
    drain();

    // Out-of-range offset used as given
    reg_write(3'd4 * REG_OFFSET_BITS, 32'd15);
    queue_random(60);
    drain();

    reg_write(3'd4 * REG_OFFSET_BITS, 32'd5);
    queue_random(120);
    drain();

    reg_write(3'd4 * REG_OFFSET_BITS, 32'd2);
    queue_random(110);
    drain();

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/savc_pkg.sv
rtl/core/savc_ctrl.sv
rtl/core/savc_dp.sv
rtl/core/set_assoc_cache_with_victim_buffer_unit.sv
tb/sv/testbench.sv
